FILE: sv/sctl_pkg.sv
// Shared types and constants for the sector cache tag and replacement engine.
// Used by sctl_way_select and sector_cache_tag_lru; no dependencies.
package sctl_pkg;

    localparam int NUM_WAYS = 4;
    localparam int NUM_SETS = 8;
    localparam int AGE_BITS = 32;

    localparam int WAY_BITS = $clog2(NUM_WAYS);
    localparam int SET_BITS = $clog2(NUM_SETS);

    localparam int SECTOR_BITS  = 32;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_DRIVE_READY_MASK = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CACHE_ENABLED    = 1'd1;

    // Response status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_READY = 2'd1;
    localparam logic [1:0] STATUS_ERROR     = 2'd2;

    typedef logic [AGE_BITS-1:0]    age_t;
    typedef logic [SECTOR_BITS-1:0] sector_t;
    typedef logic [WAY_BITS-1:0]    way_t;
    typedef logic [SET_BITS-1:0]    set_t;

    typedef logic [NUM_WAYS-1:0]                  way_bits_t;
    typedef logic [NUM_WAYS-1:0][AGE_BITS-1:0]    way_ages_t;
    typedef logic [NUM_WAYS-1:0][SECTOR_BITS-1:0] way_sectors_t;

    typedef struct packed {
        logic    drive;
        sector_t sector_number;
        logic    bypass;
        logic    fill_ok;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic       hit;
        way_t       way_used;
        logic       replaced_valid;
    } rsp_t;

    typedef struct packed {
        logic hit;
        way_t hit_way;
        way_t victim;
        logic victim_valid;
    } lookup_t;

endpackage

FILE: sv/sector_cache_tag_lru.sv
// Top level of the sector cache tag and replacement engine.
// Depends on sctl_pkg and sctl_way_select.
//
// Takes one read request per cycle while the response side does not stall,
// and returns exactly one response per request. A request is registered,
// then the tag row of its set is read, compared and aged, and the response
// and the updated tags, ages and age counter are written at the same clock
// edge, so a request that follows at once sees everything the previous one
// changed. Sustained rate is one request per clock without response stalls,
// set by the set read, four-way compare and age minimum between the request
// and response registers. The configuration port is always ready; write it
// only while no request is in flight.
module sector_cache_tag_lru (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  sctl_pkg::req_t                       req,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output sctl_pkg::rsp_t                       rsp,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sctl_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [sctl_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import sctl_pkg::*;

    // Configuration
    logic [1:0] drive_ready_mask_reg;
    logic       cache_enabled_reg;

    // Request and response stages
    req_t req_reg;
    logic req_valid_reg;
    rsp_t rsp_reg;
    rsp_t rsp_next;
    logic rsp_valid_reg;

    // Tag store, one row per set
    way_bits_t    entry_valid_reg  [NUM_SETS];
    way_bits_t    entry_drive_reg  [NUM_SETS];
    way_sectors_t entry_sector_reg [NUM_SETS];
    way_ages_t    entry_age_reg    [NUM_SETS];
    age_t         age_counter_reg;
    age_t         age_next;

    set_t    set_idx;
    lookup_t lookup;
    logic    rsp_free;
    logic    process;
    logic    update;
    way_t    upd_way;

    assign cfg_ready = 1'b1;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign process   = req_valid_reg && rsp_free;
    assign req_stall = req_valid_reg && !rsp_free;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign set_idx  = req_reg.sector_number[SET_BITS-1:0];
    assign age_next = age_counter_reg + age_t'(1);

    sctl_way_select u_way_select (
        .valid         (entry_valid_reg[set_idx]),
        .drives        (entry_drive_reg[set_idx]),
        .sectors       (entry_sector_reg[set_idx]),
        .ages          (entry_age_reg[set_idx]),
        .drive         (req_reg.drive),
        .sector_number (req_reg.sector_number),
        .lookup        (lookup)
    );

    always_comb
    begin
        rsp_next = '0;
        update   = 1'b0;
        upd_way  = lookup.hit ? lookup.hit_way : lookup.victim;
        if (!drive_ready_mask_reg[req_reg.drive])
        begin
            rsp_next.status = STATUS_NOT_READY;
        end
        else if (req_reg.bypass)
        begin
            rsp_next.status = req_reg.fill_ok ? STATUS_OK : STATUS_ERROR;
        end
        else if (!cache_enabled_reg)
        begin
            rsp_next.status = STATUS_ERROR;
        end
        else if (lookup.hit)
        begin
            rsp_next.status   = STATUS_OK;
            rsp_next.hit      = 1'b1;
            rsp_next.way_used = lookup.hit_way;
            update            = 1'b1;
        end
        else if (req_reg.fill_ok)
        begin
            rsp_next.status         = STATUS_OK;
            rsp_next.way_used       = lookup.victim;
            rsp_next.replaced_valid = lookup.victim_valid;
            update                  = 1'b1;
        end
        else
        begin
            rsp_next.status   = STATUS_ERROR;
            rsp_next.way_used = lookup.victim;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_ready_mask_reg <= '0;
            cache_enabled_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DRIVE_READY_MASK: drive_ready_mask_reg <= cfg_data[1:0];
                CFG_CACHE_ENABLED:    cache_enabled_reg    <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    // Request stage: load on every transaction, drop when processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (req_valid && !req_stall)
        begin
            req_valid_reg <= 1'b1;
        end
        else if (process)
        begin
            req_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            req_reg <= req;
        end
    end

    // Response stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_free)
        begin
            rsp_valid_reg <= process;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Valid bits, ages and age counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SETS; s++)
            begin
                entry_valid_reg[s] <= '0;
                entry_age_reg[s]   <= '0;
            end
            age_counter_reg <= '0;
        end
        else if (process && update)
        begin
            entry_valid_reg[set_idx][upd_way] <= 1'b1;
            entry_age_reg[set_idx][upd_way]   <= age_next;
            age_counter_reg                   <= age_next;
        end
    end

    // Tags change only on a fill
    always_ff @(posedge clk)
    begin
        if (process && update && !lookup.hit)
        begin
            entry_drive_reg[set_idx][upd_way]  <= req_reg.drive;
            entry_sector_reg[set_idx][upd_way] <= req_reg.sector_number;
        end
    end

endmodule

FILE: sv/sctl_way_select.sv
// Tag compare and victim choice over one set of the sector cache.
// Depends on sctl_pkg for row types and the lookup result struct.
module sctl_way_select (
    input  sctl_pkg::way_bits_t    valid,
    input  sctl_pkg::way_bits_t    drives,
    input  sctl_pkg::way_sectors_t sectors,
    input  sctl_pkg::way_ages_t    ages,
    input  logic                   drive,
    input  sctl_pkg::sector_t      sector_number,
    output sctl_pkg::lookup_t      lookup
);
    import sctl_pkg::*;

    logic hit;
    way_t hit_way;
    way_t victim;
    age_t min_age;
    logic found;

    // Priority to the lowest matching way
    always_comb
    begin
        hit     = 1'b0;
        hit_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (valid[w] && (drives[w] == drive) && (sectors[w] == sector_number))
            begin
                hit     = 1'b1;
                hit_way = WAY_BITS'(w);
            end
        end
    end

    // Take the first invalid way above way 0, else the oldest; ties keep the lower way
    always_comb
    begin
        victim  = '0;
        min_age = ages[0];
        found   = 1'b0;
        for (int w = 1; w < NUM_WAYS; w++)
        begin
            if (!found)
            begin
                if (!valid[w])
                begin
                    victim = WAY_BITS'(w);
                    found  = 1'b1;
                end
                else if (ages[w] < min_age)
                begin
                    min_age = ages[w];
                    victim  = WAY_BITS'(w);
                end
            end
        end
    end

    always_comb
    begin
        lookup.hit          = hit;
        lookup.hit_way      = hit_way;
        lookup.victim       = victim;
        lookup.victim_valid = valid[victim];
    end

endmodule

FILE: dv/sector_cache_tag_lru_tb.sv
// Self-checking testbench for sector_cache_tag_lru: directed table, then random requests.
// Depends on sctl_pkg and the RTL; predicts each response with its own tag/age model and
// checks every response transaction in order.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sctl_pkg::*;

    localparam int ENTRIES      = NUM_SETS * NUM_WAYS;
    localparam int LIMIT_CYCLES = 200_000;
    localparam int POOL         = 6;
    localparam int HOLD_CYCLES  = 300;

    typedef struct {
        logic [1:0] mask;
        logic       en;
        req_t       r;
        bit         known;
        rsp_t       want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    // side data travelling with the request transaction
    bit   row_known = 1'b0;
    rsp_t row_exp = '0;

    // predictor state
    logic    tag_valid [ENTRIES] = '{default: 1'b0};
    logic    tag_drive [ENTRIES] = '{default: 1'b0};
    sector_t tag_sector [ENTRIES] = '{default: '0};
    age_t    tag_age [ENTRIES] = '{default: '0};
    age_t    age_clock = '0;
    logic [1:0] ready_mask = 2'b00;
    logic       cache_on = 1'b0;

    rsp_t     expected_rsp_q[$];
    dir_row_t dir_rows[$];
    sector_t  sector_pool [POOL];

    int errors = 0;
    int reqs_sent = 0;
    int rsps_seen = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;

    sector_cache_tag_lru u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Response side: random stall, or a long hold-off on request from the stimulus
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic rsp_t predict_lookup(req_t r);
        rsp_t    o;
        int      base;
        int      victim;
        age_t    min_age;
        int      e;
        o = '0;
        if (!ready_mask[r.drive])
        begin
            o.status = STATUS_NOT_READY;
            return o;
        end
        if (r.bypass)
        begin
            o.status = r.fill_ok ? STATUS_OK : STATUS_ERROR;
            return o;
        end
        if (!cache_on)
        begin
            o.status = STATUS_ERROR;
            return o;
        end
        base = int'(r.sector_number % NUM_SETS) * NUM_WAYS;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            e = base + w;
            if (tag_valid[e] && tag_drive[e] == r.drive && tag_sector[e] == r.sector_number)
            begin
                age_clock = age_clock + 1'b1;
                tag_age[e] = age_clock;
                o.status = STATUS_OK;
                o.hit = 1'b1;
                o.way_used = way_t'(w);
                return o;
            end
        end
        // first invalid way from 1 up wins, else strictly oldest, ties to the lower way
        victim = 0;
        min_age = tag_age[base];
        for (int w = 1; w < NUM_WAYS; w++)
        begin
            e = base + w;
            if (!tag_valid[e])
            begin
                victim = w;
                break;
            end
            if (tag_age[e] < min_age)
            begin
                min_age = tag_age[e];
                victim = w;
            end
        end
        o.way_used = way_t'(victim);
        if (!r.fill_ok)
        begin
            o.status = STATUS_ERROR;
            return o;
        end
        e = base + victim;
        o.status = STATUS_OK;
        o.replaced_valid = tag_valid[e];
        tag_valid[e] = 1'b1;
        tag_drive[e] = r.drive;
        tag_sector[e] = r.sector_number;
        age_clock = age_clock + 1'b1;
        tag_age[e] = age_clock;
        return o;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DRIVE_READY_MASK: ready_mask = cfg_data[1:0];
                    CFG_CACHE_ENABLED:    cache_on = cfg_data[0];
                    default: ;
                endcase
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected response, expected none actual %h", $time, rsp);
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    check_field("status", 32'(want.status), 32'(rsp.status));
                    check_field("hit", 32'(want.hit), 32'(rsp.hit));
                    check_field("way_used", 32'(want.way_used), 32'(rsp.way_used));
                    check_field("replaced_valid", 32'(want.replaced_valid),
                                32'(rsp.replaced_valid));
                    rsps_seen++;
                end
            end
            if (req_valid && !req_stall)
            begin
                want = predict_lookup(req);
                expected_rsp_q.push_back(row_known ? row_exp : want);
            end
        end
    end

    function automatic void add_row(logic [1:0] mask, logic en, logic drive, sector_t sector,
                                    logic bypass, logic fill_ok, bit known,
                                    logic [1:0] status, logic hit, way_t way, logic rv);
        dir_row_t row;
        row.mask = mask;
        row.en = en;
        row.r = '{drive: drive, sector_number: sector, bypass: bypass, fill_ok: fill_ok};
        row.known = known;
        row.want = '{status: status, hit: hit, way_used: way, replaced_valid: rv};
        dir_rows.push_back(row);
    endfunction

    function automatic req_t random_req();
        req_t r;
        int   k;
        r.drive = 1'($urandom_range(1));
        k = $urandom_range(POOL - 1);
        // mostly a small tag pool per set so hits and evictions happen often
        if ($urandom_range(99) < 75)
            r.sector_number = {sector_pool[k][SECTOR_BITS-1:SET_BITS],
                               set_t'($urandom_range(NUM_SETS - 1))};
        else
            r.sector_number = $urandom;
        r.bypass = ($urandom_range(9) == 0);
        r.fill_ok = ($urandom_range(7) != 0);
        return r;
    endfunction

    // Called at a rising edge; returns at the edge where the transaction was accepted
    task automatic send_req(req_t r, bit known, rsp_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        row_known <= known;
        row_exp <= want;
        do @(posedge clk); while (req_stall);
        reqs_sent++;
    endtask

    task automatic wait_quiet();
        req_valid <= 1'b0;
        while (rsps_seen != reqs_sent)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_config(logic [1:0] mask, logic en);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_DRIVE_READY_MASK;
        cfg_data <= mask;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_CACHE_ENABLED;
        cfg_data <= {1'b0, en};
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [1:0] cur_mask;
        logic       cur_en;
        logic [1:0] seg_mask;
        logic       seg_en;
        int         seg_items;
        cur_mask = 2'b00;
        cur_en = 1'b0;

        //      mask  en  drv sector        byp fill kn status            hit way rv
        add_row(2'd0, 0, 0, 32'h0000_0000, 0, 1, 1, STATUS_NOT_READY, 0, 0, 0);
        add_row(2'd0, 0, 1, 32'hFFFF_FFFF, 1, 0, 1, STATUS_NOT_READY, 0, 0, 0);
        add_row(2'd1, 0, 0, 32'h1234_5678, 1, 1, 1, STATUS_OK,        0, 0, 0);
        add_row(2'd1, 0, 0, 32'hFFFF_FFFF, 1, 0, 1, STATUS_ERROR,     0, 0, 0);
        add_row(2'd1, 0, 0, 32'h0000_0005, 0, 1, 1, STATUS_ERROR,     0, 0, 0);
        add_row(2'd1, 0, 1, 32'h0000_0005, 0, 1, 1, STATUS_NOT_READY, 0, 0, 0);
        add_row(2'd2, 1, 0, 32'h0000_0008, 0, 1, 1, STATUS_NOT_READY, 0, 0, 0);
        add_row(2'd2, 1, 1, 32'hFFFF_FFFF, 1, 1, 1, STATUS_OK,        0, 0, 0);
        // empty set fills ways 1, 2, 3, then way 0
        add_row(2'd2, 1, 1, 32'h0000_0000, 0, 1, 1, STATUS_OK,        0, 1, 0);
        add_row(2'd3, 1, 0, 32'h0000_0008, 0, 1, 1, STATUS_OK,        0, 2, 0);
        add_row(2'd3, 1, 0, 32'h0000_0010, 0, 1, 1, STATUS_OK,        0, 3, 0);
        add_row(2'd3, 1, 1, 32'h0000_0018, 0, 1, 1, STATUS_OK,        0, 0, 0);
        add_row(2'd3, 1, 1, 32'h0000_0000, 0, 1, 0, STATUS_OK,        0, 0, 0);
        add_row(2'd3, 1, 0, 32'h0000_0000, 0, 1, 0, STATUS_OK,        0, 0, 0);
        add_row(2'd3, 1, 0, 32'h0000_0020, 0, 0, 0, STATUS_OK,        0, 0, 0);
        add_row(2'd3, 1, 0, 32'h0000_0020, 0, 1, 0, STATUS_OK,        0, 0, 0);
        add_row(2'd3, 1, 1, 32'hFFFF_FFFF, 0, 1, 0, STATUS_OK,        0, 0, 0);
        add_row(2'd3, 1, 1, 32'hFFFF_FFFF, 0, 0, 0, STATUS_OK,        0, 0, 0);
        add_row(2'd3, 1, 0, 32'hFFFF_FFFF, 0, 1, 0, STATUS_OK,        0, 0, 0);
        add_row(2'd3, 1, 0, 32'h8000_0007, 1, 0, 0, STATUS_OK,        0, 0, 0);
        add_row(2'd3, 0, 0, 32'hFFFF_FFFF, 0, 1, 1, STATUS_ERROR,     0, 0, 0);
        add_row(2'd3, 1, 1, 32'hFFFF_FFFF, 0, 1, 0, STATUS_OK,        0, 0, 0);
        add_row(2'd0, 1, 1, 32'hFFFF_FFFF, 0, 1, 1, STATUS_NOT_READY, 0, 0, 0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 19;
        recv_stall_pct = 19;
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].mask != cur_mask || dir_rows[i].en != cur_en)
            begin
                wait_quiet();
                apply_config(dir_rows[i].mask, dir_rows[i].en);
                cur_mask = dir_rows[i].mask;
                cur_en = dir_rows[i].en;
            end
            send_req(dir_rows[i].r, dir_rows[i].known, dir_rows[i].want);
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 45 : 19) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 45 : 19) : 0;
            foreach (sector_pool[k])
                sector_pool[k] = $urandom;
            for (int seg = 0; seg < 3; seg++)
            begin
                seg_mask = 2'd3;
                seg_en = 1'b1;
                seg_items = 170;
                if (seg == 1)
                begin
                    seg_mask = 2'($urandom_range(3));
                    seg_en = 1'($urandom_range(1));
                    seg_items = 40;
                end
                wait_quiet();
                apply_config(seg_mask, seg_en);
                // fill the block while the response side holds off
                if (ph == 0 && seg == 0)
                    hold_seq++;
                repeat (seg_items)
                    send_req(random_req(), 1'b0, '0);
            end
        end

        req_valid <= 1'b0;
        while (rsps_seen != reqs_sent)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (expected_rsp_q.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected responses never arrived", $time, expected_rsp_q.size());
        end
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
sv/sctl_pkg.sv
sv/sctl_way_select.sv
sv/sector_cache_tag_lru.sv
dv/sector_cache_tag_lru_tb.sv
